### rtl/core/lse_pkg.sv
// shared types, constants and helpers for the lsb stego embed/extract block
package lse_pkg;

  localparam int MSG_DEPTH = 1024;
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam int MSG_CW    = $clog2(MSG_DEPTH + 1);

  localparam int BP_W   = 26;
  localparam int BIDX_W = BP_W - 3;
  localparam int PIX_W  = 24;
  localparam int CAP_W  = PIX_W + 2;
  localparam int MLEN_W = 11;
  localparam int TOT_W  = MLEN_W + 4;
  localparam int LIM_W  = 36;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PIXELS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MSGLEN = 2'd2;

  localparam logic KIND_MSG   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic MODE_EMBED = 1'b0;

  localparam int LEN_BITS = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [BP_W-1:0] bp;
    logic [31:0]     len_sh;
    logic [7:0]      byte_sh;
    status_t         err;
  } frame_state_t;

  typedef struct packed {
    logic [2:0][7:0] rgb;
    logic            byte_valid;
    logic [7:0]      message_byte;
    logic            done;
    status_t         status;
  } pix_result_t;

  // byte of the message that holds bit position bp
  function automatic logic [BIDX_W-1:0] byte_index(input logic [BP_W-1:0] bp);
    logic [BP_W-1:0] off;
    off = bp - BP_W'(LEN_BITS);
    if (bp < BP_W'(LEN_BITS)) begin
      byte_index = '0;
    end else begin
      byte_index = off[BP_W-1:3];
    end
  endfunction

endpackage

### rtl/core/lse_msg_ram.sv
// message buffer: one write port, two registered read ports with write bypass
module lse_msg_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lse_pkg::MSG_AW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [lse_pkg::MSG_AW-1:0] raddr0,
  input  logic [lse_pkg::MSG_AW-1:0] raddr1,
  output logic [7:0]                rdata0,
  output logic [7:0]                rdata1
);

  logic [7:0] mem [lse_pkg::MSG_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr0)) begin
      rdata0 <= wdata;
    end else begin
      rdata0 <= mem[raddr0];
    end
    if (we && (waddr == raddr1)) begin
      rdata1 <= wdata;
    end else begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### rtl/core/lse_bit_engine.sv
// per-pixel embed/extract of three lsbs and next frame state
module lse_bit_engine (
  input  logic                         mode,
  input  logic [lse_pkg::PIX_W-1:0]    pixel_count,
  input  logic [lse_pkg::MLEN_W-1:0]   message_length,
  input  lse_pkg::frame_state_t        st,
  input  logic [2:0][7:0]              rgb,
  input  logic [7:0]                   cur_byte,
  input  logic [7:0]                   nxt_byte,
  output lse_pkg::frame_state_t        st_nxt,
  output lse_pkg::pix_result_t         res
);

  always_comb begin
    logic [lse_pkg::PIX_W-1:0]  pc;
    logic [lse_pkg::CAP_W-1:0]  cap;
    logic [lse_pkg::TOT_W-1:0]  total;
    logic [lse_pkg::BIDX_W-1:0] k;
    logic [lse_pkg::BP_W-1:0]   bp;
    logic [lse_pkg::BP_W-1:0]   off;
    logic [31:0]                ls;
    logic [31:0]                ml32;
    logic [7:0]                 bs;
    logic [7:0]                 src;
    logic [lse_pkg::LIM_W-1:0]  lim;
    logic [2:0][7:0]            ch;
    logic                       b;
    logic                       stop;
    logic                       valid;
    logic [7:0]                 mbyte;
    logic                       done;
    lse_pkg::status_t           err;

    pc    = (pixel_count == '0) ? lse_pkg::PIX_W'(1) : pixel_count;
    cap   = {2'b00, pc} + {1'b0, pc, 1'b0};
    total = {message_length, 3'b000} + lse_pkg::TOT_W'(lse_pkg::LEN_BITS);
    k     = lse_pkg::byte_index(st.bp);
    ml32  = {{(32 - lse_pkg::MLEN_W){1'b0}}, message_length};
    bp    = st.bp;
    ls    = st.len_sh;
    bs    = st.byte_sh;
    ch    = rgb;
    err   = st.err;
    stop  = 1'b0;
    valid = 1'b0;
    mbyte = '0;
    done  = 1'b0;
    off   = '0;
    src   = '0;
    b     = 1'b0;
    lim   = '0;

    if (err == lse_pkg::ST_OK) begin
      if (mode == lse_pkg::MODE_EMBED) begin
        if ((message_length > lse_pkg::MLEN_W'(lse_pkg::MSG_DEPTH)) ||
            ({{(lse_pkg::CAP_W - lse_pkg::TOT_W){1'b0}}, total} > cap)) begin
          err = lse_pkg::ST_TOO_LONG;
        end
      end else if (cap < lse_pkg::CAP_W'(lse_pkg::LEN_BITS)) begin
        err = lse_pkg::ST_NO_ROOM;
      end
    end

    if (err == lse_pkg::ST_OK) begin
      for (int c = 0; c < 3; c++) begin
        if (!stop) begin
          if (mode == lse_pkg::MODE_EMBED) begin
            if (bp < {{(lse_pkg::BP_W - lse_pkg::TOT_W){1'b0}}, total}) begin
              if (bp < lse_pkg::BP_W'(lse_pkg::LEN_BITS)) begin
                b = ml32[5'd31 - bp[4:0]];
              end else begin
                off = bp - lse_pkg::BP_W'(lse_pkg::LEN_BITS);
                src = (off[lse_pkg::BP_W-1:3] == k) ? cur_byte : nxt_byte;
                b   = src[3'd7 - off[2:0]];
              end
              ch[c] = {ch[c][7:1], b};
              bp    = bp + lse_pkg::BP_W'(1);
            end
          end else begin
            b   = ch[c][0];
            lim = lse_pkg::LIM_W'(lse_pkg::LEN_BITS) + {ls, 3'b000};
            if (bp < lse_pkg::BP_W'(lse_pkg::LEN_BITS)) begin
              ls  = {ls[30:0], b};
              bp  = bp + lse_pkg::BP_W'(1);
              lim = lse_pkg::LIM_W'(lse_pkg::LEN_BITS) + {ls, 3'b000};
              if ((bp == lse_pkg::BP_W'(lse_pkg::LEN_BITS)) &&
                  (lim > lse_pkg::LIM_W'(cap))) begin
                err  = lse_pkg::ST_TRUNCATED;
                stop = 1'b1;
              end
            end else if (lse_pkg::LIM_W'(bp) < lim) begin
              bs = {bs[6:0], b};
              bp = bp + lse_pkg::BP_W'(1);
              if (bp[2:0] == 3'b000) begin
                valid = 1'b1;
                mbyte = bs;
              end
            end
          end
        end
      end
      if (err == lse_pkg::ST_OK) begin
        lim = lse_pkg::LIM_W'(lse_pkg::LEN_BITS) + {ls, 3'b000};
        if (mode == lse_pkg::MODE_EMBED) begin
          done = (bp >= {{(lse_pkg::BP_W - lse_pkg::TOT_W){1'b0}}, total});
        end else begin
          done = (bp >= lse_pkg::BP_W'(lse_pkg::LEN_BITS)) && (lse_pkg::LIM_W'(bp) >= lim);
        end
      end
    end

    st_nxt.bp        = bp;
    st_nxt.len_sh    = ls;
    st_nxt.byte_sh   = bs;
    st_nxt.err       = err;
    res.rgb          = ch;
    res.byte_valid   = valid;
    res.message_byte = mbyte;
    res.done         = done;
    res.status       = err;
  end

endmodule

### rtl/core/lsb_stego_embed_extract.sv
// top level: lsb steganography embed/extract over an rgb pixel stream
//
// in_* carries message bytes (tuser 0) or pixels (tuser 1). message bytes fill
// a 1024-byte buffer and give no transfer on out_*. each pixel gives exactly
// one out_* transfer: the pixel with the 32-bit length and message bits
// written into the r, g, b lsbs (embed), or unchanged with an extracted byte
// flagged in out_tuser (extract), plus done and status.
// cfg_* writes mode (index 0), pixel count (1) and message length (2);
// cfg_ready is always high and writes are expected only while idle.
// the result of an accepted pixel is registered and held on out_* until taken.
// throughput: one item per cycle while out_* is not stalled. the buffer is read on
// two registered ports ahead of use, addressed from the next bit position, with
// write bypass, so a byte written just before a pixel is seen by it.
// reset: config returns to embed, one pixel, length zero; all counters and the
// latched status clear; buffer contents are undefined until written.
// stall: with out_tvalid high and out_tready low the result holds and in_tready
// drops; at the last pixel of an image all counters clear for the next image.
module lsb_stego_embed_extract (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // message_in, red, green, blue
  input  logic                       in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata,  // red_out, green_out, blue_out,
                                                 // message_byte, message_done,
                                                 // status, zero pad
  output logic                       out_tuser,  // byte_valid
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lse_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lse_pkg::CFG_DW-1:0] cfg_data
);

  logic                        mode_r, mode_nxt;
  logic [lse_pkg::PIX_W-1:0]   pc_r, pc_nxt;
  logic [lse_pkg::MLEN_W-1:0]  ml_r, ml_nxt;
  logic [lse_pkg::MSG_CW-1:0]  swi_r, swi_nxt;
  logic [lse_pkg::PIX_W-1:0]   pix_r, pix_nxt;
  lse_pkg::frame_state_t       st_r, st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lse_pkg::pix_result_t        res_r, res_nxt;

  lse_pkg::frame_state_t       eng_st;
  lse_pkg::pix_result_t        eng_res;
  logic [7:0]                  rd0, rd1;
  logic                        in_xfer, pix_xfer, msg_xfer;
  logic                        we;
  logic [lse_pkg::MSG_AW-1:0]  ra0, ra1;
  logic [lse_pkg::PIX_W-1:0]   pc_eff;
  logic [lse_pkg::PIX_W:0]     pix_inc;
  logic                        frame_end;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign pix_xfer  = in_xfer && (in_tuser == lse_pkg::KIND_PIXEL);
  assign msg_xfer  = in_xfer && (in_tuser == lse_pkg::KIND_MSG);
  assign we        = msg_xfer && (swi_r < lse_pkg::MSG_CW'(lse_pkg::MSG_DEPTH));
  assign pc_eff    = (pc_r == '0) ? lse_pkg::PIX_W'(1) : pc_r;
  assign pix_inc   = {1'b0, pix_r} + (lse_pkg::PIX_W + 1)'(1);
  assign frame_end = (pix_inc >= {1'b0, pc_eff});

  lse_bit_engine u_engine (
    .mode           (mode_r),
    .pixel_count    (pc_r),
    .message_length (ml_r),
    .st             (st_r),
    .rgb            (in_tdata[31:8]),
    .cur_byte       (rd0),
    .nxt_byte       (rd1),
    .st_nxt         (eng_st),
    .res            (eng_res)
  );

  lse_msg_ram u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (swi_r[lse_pkg::MSG_AW-1:0]),
    .wdata  (in_tdata[7:0]),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  assign ra0 = lse_pkg::MSG_AW'(lse_pkg::byte_index(st_nxt.bp));
  assign ra1 = ra0 + lse_pkg::MSG_AW'(1);

  always_comb begin
    mode_nxt      = mode_r;
    pc_nxt        = pc_r;
    ml_nxt        = ml_r;
    swi_nxt       = swi_r;
    pix_nxt       = pix_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lse_pkg::CFG_MODE:   mode_nxt = cfg_data[0];
        lse_pkg::CFG_PIXELS: pc_nxt   = cfg_data;
        lse_pkg::CFG_MSGLEN: ml_nxt   = cfg_data[lse_pkg::MLEN_W-1:0];
        default: ;
      endcase
    end

    if (we) begin
      swi_nxt = swi_r + lse_pkg::MSG_CW'(1);
    end

    if (pix_xfer) begin
      res_nxt       = eng_res;
      out_valid_nxt = 1'b1;
      if (frame_end) begin
        pix_nxt = '0;
        swi_nxt = '0;
        st_nxt  = '0;
      end else begin
        pix_nxt = pix_inc[lse_pkg::PIX_W-1:0];
        st_nxt  = eng_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lse_pkg::MODE_EMBED;
      pc_r        <= lse_pkg::PIX_W'(1);
      ml_r        <= '0;
      swi_r       <= '0;
      pix_r       <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pc_r        <= pc_nxt;
      ml_r        <= ml_nxt;
      swi_r       <= swi_nxt;
      pix_r       <= pix_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.byte_valid;
  assign out_tdata  = {5'b00000, res_r.status, res_r.done, res_r.message_byte, res_r.rgb};

endmodule

### test/lse_checker.sv
// checker: predicts each pixel result of the stego block and compares the out_* stream
module lse_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [31:0]                in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [39:0]                out_tdata,
  input  logic                       out_tuser,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [lse_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lse_pkg::CFG_DW-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count,
  output int                         byte_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lse_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       byte_valid;
    logic [7:0] message_byte;
    logic       message_done;
    status_t    status;
  } pixel_out_t;

  // configuration copy
  logic              mode_r;
  logic [PIX_W-1:0]  npix;
  logic [MLEN_W-1:0] msglen;

  // image state
  logic [7:0]        msg_mem [MSG_DEPTH];
  logic [MSG_CW-1:0] wr_ptr;
  logic [PIX_W-1:0]  pix_idx;
  logic [BP_W-1:0]   bitpos;
  logic [31:0]       len_sr;
  logic [7:0]        byte_sr;
  status_t           latched;

  pixel_out_t expected_pixels [$];

  initial begin
    fail_count   = 0;
    result_count = 0;
    byte_count   = 0;
    pending      = 0;
  end

  function automatic void new_frame();
    pix_idx = '0;
    bitpos  = '0;
    len_sr  = '0;
    byte_sr = '0;
    latched = ST_OK;
    wr_ptr  = '0;
  endfunction

  // bit pos of the framed message: 32-bit length, then the buffered bytes, msb first
  function automatic logic framed_bit(logic [BP_W-1:0] pos);
    logic [31:0] len32;
    int          off;
    len32 = 32'(msglen);
    if (int'(pos) < LEN_BITS) return len32[31 - int'(pos)];
    off = int'(pos) - LEN_BITS;
    if ((off >> 3) >= MSG_DEPTH) return 1'b0;
    return msg_mem[off >> 3][7 - (off & 7)];
  endfunction

  function automatic pixel_out_t stego_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_out_t res;
    logic [7:0] ch [3];
    logic [PIX_W-1:0] pc;
    longint cap;
    longint total;
    logic halt;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    res   = '0;
    halt  = 1'b0;
    pc    = (npix == '0) ? PIX_W'(1) : npix;
    cap   = 3 * longint'(pc);
    total = 0;
    if (latched == ST_OK) begin
      if (mode_r == MODE_EMBED) begin
        total = LEN_BITS + 8 * longint'(msglen);
        if (int'(msglen) > MSG_DEPTH || total > cap) latched = ST_TOO_LONG;
      end else if (cap < LEN_BITS) begin
        latched = ST_NO_ROOM;
      end
    end
    if (latched == ST_OK) begin
      for (int c = 0; c < 3; c++) begin
        if (!halt) begin
          if (mode_r == MODE_EMBED) begin
            if (longint'(bitpos) < total) begin
              ch[c][0] = framed_bit(bitpos);
              bitpos++;
            end
          end else if (int'(bitpos) < LEN_BITS) begin
            len_sr = {len_sr[30:0], ch[c][0]};
            bitpos++;
            if (int'(bitpos) == LEN_BITS && LEN_BITS + 8 * longint'(len_sr) > cap) begin
              latched = ST_TRUNCATED;
              halt    = 1'b1;
            end
          end else if (longint'(bitpos) < LEN_BITS + 8 * longint'(len_sr)) begin
            byte_sr = {byte_sr[6:0], ch[c][0]};
            bitpos++;
            if (bitpos[2:0] == 3'd0) begin
              res.byte_valid   = 1'b1;
              res.message_byte = byte_sr;
            end
          end
        end
      end
      if (latched == ST_OK) begin
        if (mode_r == MODE_EMBED) begin
          res.message_done = longint'(bitpos) >= total;
        end else begin
          res.message_done = int'(bitpos) >= LEN_BITS &&
                             longint'(bitpos) >= LEN_BITS + 8 * longint'(len_sr);
        end
      end
    end
    res.red    = ch[0];
    res.green  = ch[1];
    res.blue   = ch[2];
    res.status = latched;
    pix_idx++;
    if (pix_idx >= pc) new_frame();
    return res;
  endfunction

  task automatic compare(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (!rst_n) begin
      mode_r = MODE_EMBED;
      npix   = PIX_W'(1);
      msglen = '0;
      new_frame();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   mode_r = cfg_data[0];
          CFG_PIXELS: npix   = cfg_data[PIX_W-1:0];
          CFG_MSGLEN: msglen = cfg_data[MLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        if (out_tuser) byte_count++;
        if (expected_pixels.size() == 0) begin
          $error("result transfer with no pixel outstanding: tdata %0h", out_tdata);
          fail_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          compare("red_out", exp_px.red, out_tdata[7:0]);
          compare("green_out", exp_px.green, out_tdata[15:8]);
          compare("blue_out", exp_px.blue, out_tdata[23:16]);
          compare("byte_valid", 8'(exp_px.byte_valid), 8'(out_tuser));
          compare("message_byte", exp_px.message_byte, out_tdata[31:24]);
          compare("message_done", 8'(exp_px.message_done), 8'(out_tdata[32]));
          compare("status", 8'(exp_px.status), 8'(out_tdata[34:33]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_MSG) begin
          if (int'(wr_ptr) < MSG_DEPTH) begin
            msg_mem[wr_ptr[MSG_AW-1:0]] = in_tdata[7:0];
            wr_ptr++;
          end
        end else begin
          expected_pixels.insert(expected_pixels.size(),
                                 stego_pixel(in_tdata[15:8], in_tdata[23:16],
                                             in_tdata[31:24]));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

### test/tb_lsb_stego_embed_extract.sv
// testbench top: drives message bytes, pixels and config into the stego block, gives the verdict
module tb_lsb_stego_embed_extract;
  timeunit 1ns;
  timeprecision 1ps;
  import lse_pkg::*;

  localparam logic MODE_EXTRACT = ~MODE_EMBED;
  localparam int   RANDOM_ITEMS = 270;
  localparam int   LONG_MSG     = 24;
  localparam int   LONG_HOLD    = 80;
  localparam int   SETTLE       = 4;
  localparam int   WD_LIMIT     = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [39:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  int fail_count;
  int pending;
  int result_count;
  int byte_count;

  logic jitter;
  logic hold_req;
  int   sent;
  int   n_embed;
  int   n_extract;

  lsb_stego_embed_extract i_dut (.*);
  lse_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pixels_for(int len);
    return (LEN_BITS + 8 * len + 2) / 3;
  endfunction

  task automatic send_item(logic kind, logic [7:0] msg, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    int gap;
    if (jitter && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {b, g, r, msg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] msg);
    send_item(KIND_MSG, msg, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_item(KIND_PIXEL, 8'($urandom), r, g, b);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic m, logic [PIX_W-1:0] pc, logic [MLEN_W-1:0] len);
    logic [CFG_DW-1:0] vals [3];
    logic [CFG_IW-1:0] regs [3];
    drain();
    regs[0] = CFG_MODE;
    vals[0] = CFG_DW'(m);
    regs[1] = CFG_PIXELS;
    vals[1] = CFG_DW'(pc);
    regs[2] = CFG_MSGLEN;
    vals[2] = CFG_DW'(len);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic embed_image(int len, int pc, int load);
    set_config(MODE_EMBED, PIX_W'(pc), MLEN_W'(len));
    repeat (load) send_byte(8'($urandom));
    repeat ((pc == 0) ? 1 : pc) begin
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom));
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    n_embed++;
  endtask

  // pixel lsbs carry len_field, then body_n random bytes, then noise
  task automatic extract_image(logic [31:0] len_field, int body_n, int pc);
    logic [7:0] body [$];
    logic [7:0] ch [3];
    int pos;
    set_config(MODE_EXTRACT, PIX_W'(pc), MLEN_W'($urandom));
    repeat (body_n) body.insert(body.size(), 8'($urandom));
    for (int p = 0; p < ((pc == 0) ? 1 : pc); p++) begin
      for (int c = 0; c < 3; c++) begin
        pos   = 3 * p + c;
        ch[c] = 8'($urandom);
        if (pos < LEN_BITS) begin
          ch[c][0] = len_field[31 - pos];
        end else if ((pos - LEN_BITS) / 8 < body_n) begin
          ch[c][0] = body[(pos - LEN_BITS) / 8][7 - (pos - LEN_BITS) % 8];
        end
      end
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom));
      send_pixel(ch[0], ch[1], ch[2]);
    end
    n_extract++;
  endtask

  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (jitter && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WD_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int base;
    int pick;
    int len;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_MSG;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    jitter    <= 1'b0;
    hold_req  <= 1'b0;
    sent      = 0;
    n_embed   = 0;
    n_extract = 0;
    repeat (6) @(posedge clk);
    rst_n  <= 1'b1;
    jitter <= 1'b1;
    @(posedge clk);

    // a few bytes at the reset config, then close single-pixel images
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (4) send_byte(8'($urandom));
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);

    // embed corner cases
    embed_image(0, 0, 0);
    embed_image(2047, 6, 0);
    embed_image(1, pixels_for(1), 1);
    embed_image(0, pixels_for(0), 0);
    embed_image(0, pixels_for(0) - 1, 0);
    set_config(MODE_EMBED, PIX_W'(pixels_for(MSG_DEPTH + 1)), MLEN_W'(MSG_DEPTH + 1));
    repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    set_config(MODE_EMBED, PIX_W'(1), MLEN_W'(MSG_DEPTH + 1));
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // extract corner cases
    extract_image(32'd0, 0, pixels_for(0));
    extract_image(32'd1, 1, pixels_for(1));
    extract_image(32'd0, 0, pixels_for(0) - 1);
    extract_image(32'd0, 0, 0);
    extract_image(32'hFFFF_FFFF, 0, pixels_for(0));

    // mode switch partway through an image
    set_config(MODE_EMBED, PIX_W'(30), MLEN_W'(2));
    repeat (2) send_byte(8'($urandom));
    repeat (5) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    set_config(MODE_EXTRACT, PIX_W'(30), MLEN_W'(2));
    repeat (25) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // largest image size, cut short by shrinking the pixel count
    set_config(MODE_EMBED, {PIX_W{1'b1}}, MLEN_W'(3));
    repeat (3) send_byte(8'($urandom));
    repeat (25) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    set_config(MODE_EMBED, PIX_W'(1), MLEN_W'(3));
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // long message both ways; output held off for a while so input backs up
    set_config(MODE_EMBED, PIX_W'(pixels_for(LONG_MSG)), MLEN_W'(LONG_MSG));
    repeat (LONG_MSG) send_byte(8'($urandom));
    hold_req <= 1'b1;
    repeat (pixels_for(LONG_MSG)) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    n_embed++;
    extract_image(32'(LONG_MSG), LONG_MSG, pixels_for(LONG_MSG));

    // random images, mostly well formed
    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      if (sent - base > RANDOM_ITEMS - 100) jitter <= 1'b0;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 40) begin
        embed_image(len, pixels_for(len) + $urandom_range(0, 3),
                    len + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0));
      end else if (pick < 47) begin
        embed_image(len, pixels_for(len) - $urandom_range(1, 3), len);
      end else if (pick < 50) begin
        embed_image($urandom_range(MSG_DEPTH + 1, 2047), $urandom_range(1, 6), 0);
      end else if (pick < 85) begin
        extract_image(32'(len), len, pixels_for(len) + $urandom_range(0, 3));
      end else if (pick < 93) begin
        extract_image(32'(len), len, pixels_for(len) - $urandom_range(1, 3));
      end else if (pick < 97) begin
        extract_image($urandom, 0, $urandom_range(0, 20));
      end else begin
        embed_image(0, $urandom_range(0, 1), 0);
      end
    end

    drain();
    $display("run covered %0d pixel results and %0d recovered message bytes", result_count,
             byte_count);
    $display("over %0d embed and %0d extract images, incl. overflow, truncation and mode switch",
             n_embed, n_extract);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
